@@ hdl/assert_macros.svh @@
// assertion macros shared by the framer modules
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hdl/rcf_pkg.sv @@
// types, constants and crc helper for the rpc command framer
// no dependencies; imported by every framer module
package rcf_pkg;

    localparam logic [15:0] CMD_HDR_MAGIC  = 16'h1209;
    localparam logic [15:0] CMD_DATA_MAGIC = 16'hABD1;
    localparam logic [15:0] RES_HDR_MAGIC  = 16'h9021;
    localparam logic [15:0] RES_DATA_MAGIC = 16'h1DBA;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CRC_SEED       = 16'hFFFF;
    localparam logic [31:0] HASH_SEED      = 32'd5381;

    // last byte index of each packet kind
    localparam logic [3:0] HDR_LAST_IDX   = 4'd11;
    localparam logic [3:0] HDR_CRC_LO_IDX = 4'd10;
    localparam logic [3:0] REQ_LAST_IDX   = 4'd3;
    localparam logic [3:0] REQ_CRC_LO_IDX = 4'd2;
    localparam logic [3:0] PAIR_LAST_IDX  = 4'd1;

    typedef enum logic [2:0] {
        OP_NAME       = 3'd0,
        OP_HEADER     = 3'd1,
        OP_DATA_START = 3'd2,
        OP_PAYLOAD    = 3'd3,
        OP_DATA_END   = 3'd4,
        OP_ACK        = 3'd5,
        OP_REQUEST    = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ACK_OK           = 2'd0,
        ACK_CRC_MISMATCH = 2'd1,
        ACK_WRONG_MAGIC  = 2'd2
    } t_ack_status;

    typedef enum logic [2:0] {
        CMD_HEADER,
        CMD_DATA_START,
        CMD_PAYLOAD,
        CMD_DATA_END,
        CMD_VERDICT,
        CMD_REQUEST
    } t_cmd_op;

    localparam logic KIND_TX      = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // one queued job for the back end
    // arg: header {length, hash}, payload byte in [7:0], data end crc in [15:0]
    typedef struct packed {
        t_cmd_op     op;
        logic [63:0] arg;
        logic        sel;
        t_ack_status status;
    } t_cmd;

    // crc-16, poly 0x1021, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // crc after the two data magic bytes
    localparam logic [15:0] DATA_START_CRC =
        crc_byte(crc_byte(CRC_SEED, CMD_DATA_MAGIC[7:0]), CMD_DATA_MAGIC[15:8]);

endpackage

@@ hdl/rpc_command_framer_unit.sv @@
// top level of the rpc command framer (transmit side of a uart rpc link)
// depends on rcf_pkg, rcf_front, rcf_queue, rcf_back
//
// usage:
//   input channel (i_valid / o_stall): one beat per op - name byte, header,
//   data start, payload byte, data end, received ack byte or result request.
//   a beat is taken at a rising edge with i_valid high and o_stall low.
//   output channel (o_valid / i_stall): one beat per result - a link byte
//   (o_kind 0) or an ack verdict (o_kind 1); o_last marks the final result
//   of an input beat. results leave in input order, fields little-endian.
// path: the edge that takes a beat writes its job into the queue; the back
//   end then loads its first result from the queue head into the output register.
// throughput: unless the receiver stalls, the back end emits one result
//   per cycle, so ops with one result or none run at one beat per cycle; a
//   header holds the back end for 12 bytes, data start and data end for 2,
//   a request for 4. the header and request crc is built a byte per cycle as bytes go out.
// stall: with the receiver stalling, the output register holds its beat,
//   the queue of QUEUE_DEPTH jobs fills and o_stall rises; name bytes and
//   the first three ack bytes also stall then, as the front takes nothing
//   while the queue is full.
// reset: i_rst_n low at an edge clears the hash to 5381, the data crc to
//   0xffff, the partly received ack, the queue and the output valid.
module rpc_command_framer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_payload_length,
    input  logic        i_select_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [1:0]  o_ack_status,
    output logic        o_last
);
    import rcf_pkg::*;

    // front to queue
    logic  push;
    t_cmd  push_cmd;
    // queue status and head toward back end
    logic  q_full;
    logic  q_empty;
    logic  pop;
    t_cmd  head_cmd;

    // classify beats and keep running hash / crc / ack state
    rcf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_data_byte      (i_data_byte),
        .i_payload_length (i_payload_length),
        .i_select_data    (i_select_data),
        .i_full           (q_full),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    // decouples the front from output back pressure
    rcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    // serialize each job into output beats
    rcf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_head       (head_cmd),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_tx_byte    (o_tx_byte),
        .o_ack_status (o_ack_status),
        .o_last       (o_last)
    );

endmodule

@@ hdl/rcf_front.sv @@
// front end: accepts input beats, keeps hash / data crc / ack state
// and pushes packet jobs to the queue; depends on rcf_pkg
module rcf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [2:0]    i_op,
    input  logic [7:0]    i_data_byte,
    input  logic [31:0]   i_payload_length,
    input  logic          i_select_data,
    input  logic          i_full,
    output logic          o_push,
    output rcf_pkg::t_cmd o_cmd
);
    import rcf_pkg::*;

    logic [31:0] r_hash,      n_hash;
    logic [15:0] r_data_crc,  n_data_crc;
    logic [1:0]  r_ack_idx,   n_ack_idx;
    logic [15:0] r_ack_crc,   n_ack_crc;
    logic [15:0] r_ack_magic, n_ack_magic;
    logic [7:0]  r_ack_crc_lo, n_ack_crc_lo;

    logic        accept;
    logic [15:0] rx_crc;
    logic [15:0] expect_magic;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign rx_crc       = {i_data_byte, r_ack_crc_lo};
    assign expect_magic = i_select_data ? CMD_DATA_MAGIC : CMD_HDR_MAGIC;

    always_comb begin
        n_hash       = r_hash;
        n_data_crc   = r_data_crc;
        n_ack_idx    = r_ack_idx;
        n_ack_crc    = r_ack_crc;
        n_ack_magic  = r_ack_magic;
        n_ack_crc_lo = r_ack_crc_lo;
        o_push       = 1'b0;
        o_cmd.op     = CMD_PAYLOAD;
        o_cmd.arg    = {32'h0, r_hash};
        o_cmd.sel    = i_select_data;
        o_cmd.status = ACK_OK;
        case (t_op'(i_op))
            OP_NAME: begin
                n_hash = ({r_hash[26:0], 5'b0} + r_hash) ^ {24'h0, i_data_byte};
            end
            OP_HEADER: begin
                o_push    = 1'b1;
                o_cmd.op  = CMD_HEADER;
                o_cmd.arg = {i_payload_length, r_hash};
                n_hash    = HASH_SEED;
            end
            OP_DATA_START: begin
                o_push     = 1'b1;
                o_cmd.op   = CMD_DATA_START;
                n_data_crc = DATA_START_CRC;
            end
            OP_PAYLOAD: begin
                o_push     = 1'b1;
                o_cmd.op   = CMD_PAYLOAD;
                o_cmd.arg  = {56'h0, i_data_byte};
                n_data_crc = crc_byte(r_data_crc, i_data_byte);
            end
            OP_DATA_END: begin
                o_push     = 1'b1;
                o_cmd.op   = CMD_DATA_END;
                o_cmd.arg  = {48'h0, r_data_crc};
                n_data_crc = CRC_SEED;
            end
            OP_ACK: begin
                if (r_ack_idx inside {2'd0, 2'd1}) begin
                    if (r_ack_idx == 2'd0) begin
                        n_ack_magic = {r_ack_magic[15:8], i_data_byte};
                    end else begin
                        n_ack_magic = {i_data_byte, r_ack_magic[7:0]};
                    end
                    n_ack_crc = crc_byte(r_ack_crc, i_data_byte);
                    n_ack_idx = r_ack_idx + 2'd1;
                end else if (r_ack_idx == 2'd2) begin
                    n_ack_crc_lo = i_data_byte;
                    n_ack_idx    = 2'd3;
                end else begin
                    o_push   = 1'b1;
                    o_cmd.op = CMD_VERDICT;
                    if (rx_crc != r_ack_crc) begin
                        o_cmd.status = ACK_CRC_MISMATCH;
                    end else if (r_ack_magic != expect_magic) begin
                        o_cmd.status = ACK_WRONG_MAGIC;
                    end
                end
            end
            OP_REQUEST: begin
                o_push   = 1'b1;
                o_cmd.op = CMD_REQUEST;
            end
            default: begin
            end
        endcase
        // new exchange or finished verdict flushes the ack collection
        if (t_op'(i_op) inside {OP_HEADER, OP_DATA_END, OP_REQUEST} ||
            (t_op'(i_op) == OP_ACK && r_ack_idx == 2'd3)) begin
            n_ack_idx    = 2'd0;
            n_ack_crc    = CRC_SEED;
            n_ack_magic  = 16'h0;
            n_ack_crc_lo = 8'h0;
        end
        o_push = o_push && accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash       <= HASH_SEED;
            r_data_crc   <= CRC_SEED;
            r_ack_idx    <= 2'd0;
            r_ack_crc    <= CRC_SEED;
            r_ack_magic  <= 16'h0;
            r_ack_crc_lo <= 8'h0;
        end else if (accept) begin
            r_hash       <= n_hash;
            r_data_crc   <= n_data_crc;
            r_ack_idx    <= n_ack_idx;
            r_ack_crc    <= n_ack_crc;
            r_ack_magic  <= n_ack_magic;
            r_ack_crc_lo <= n_ack_crc_lo;
        end
    end

endmodule

@@ hdl/rcf_queue.sv @@
// job queue between front and back end
// depends on rcf_pkg and assert_macros.svh
`include "assert_macros.svh"

module rcf_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rcf_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output rcf_pkg::t_cmd o_head
);
    import rcf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_slots [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_slots[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

    `ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop, !o_empty)
    `ASSERT_IMPLY(a_pop_has_job, i_clk, i_rst_n, i_pop, !o_empty)

endmodule

@@ hdl/rcf_back.sv @@
// back end: walks each queued job byte by byte into the output register,
// runs the packet crc as bytes go out; depends on rcf_pkg, assert_macros.svh
`include "assert_macros.svh"

module rcf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  rcf_pkg::t_cmd i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_kind,
    output logic [7:0]    o_tx_byte,
    output logic [1:0]    o_ack_status,
    output logic          o_last
);
    import rcf_pkg::*;

    logic        r_valid;
    logic [3:0]  r_idx,  n_idx;
    logic [15:0] r_crc,  n_crc;
    logic        r_kind;
    logic [7:0]  r_tx_byte;
    logic [1:0]  r_ack_status;
    logic        r_last;

    logic        advance;
    logic        load;
    logic        sel_kind;
    logic [7:0]  sel_byte;
    logic [1:0]  sel_status;
    logic        sel_last;
    logic [15:0] crc_cur;
    logic [79:0] hdr_word;
    logic [15:0] req_magic;

    assign advance   = !r_valid || !i_stall;
    assign load      = advance && !i_empty;
    assign crc_cur   = (r_idx == '0) ? CRC_SEED : r_crc;
    assign hdr_word  = {i_head.arg, CMD_HDR_MAGIC};
    assign req_magic = i_head.sel ? RES_DATA_MAGIC : RES_HDR_MAGIC;

    always_comb begin
        sel_kind   = KIND_TX;
        sel_byte   = 8'h00;
        sel_status = ACK_OK;
        sel_last   = 1'b0;
        n_crc      = r_crc;
        case (i_head.op)
            CMD_HEADER: begin
                sel_last = (r_idx == HDR_LAST_IDX);
                if (r_idx == HDR_CRC_LO_IDX) begin
                    sel_byte = r_crc[7:0];
                end else if (r_idx == HDR_LAST_IDX) begin
                    sel_byte = r_crc[15:8];
                end else begin
                    sel_byte = 8'(hdr_word >> {r_idx, 3'b000});
                    n_crc    = crc_byte(crc_cur, sel_byte);
                end
            end
            CMD_REQUEST: begin
                sel_last = (r_idx == REQ_LAST_IDX);
                if (r_idx == REQ_CRC_LO_IDX) begin
                    sel_byte = r_crc[7:0];
                end else if (r_idx == REQ_LAST_IDX) begin
                    sel_byte = r_crc[15:8];
                end else begin
                    sel_byte = r_idx[0] ? req_magic[15:8] : req_magic[7:0];
                    n_crc    = crc_byte(crc_cur, sel_byte);
                end
            end
            CMD_DATA_START: begin
                sel_last = (r_idx == PAIR_LAST_IDX);
                sel_byte = r_idx[0] ? CMD_DATA_MAGIC[15:8] : CMD_DATA_MAGIC[7:0];
            end
            CMD_PAYLOAD: begin
                sel_last = 1'b1;
                sel_byte = i_head.arg[7:0];
            end
            CMD_DATA_END: begin
                sel_last = (r_idx == PAIR_LAST_IDX);
                sel_byte = r_idx[0] ? i_head.arg[15:8] : i_head.arg[7:0];
            end
            CMD_VERDICT: begin
                sel_kind   = KIND_VERDICT;
                sel_status = i_head.status;
                sel_last   = 1'b1;
            end
            default: begin
                sel_last = 1'b1;
            end
        endcase
        n_idx = sel_last ? 4'd0 : r_idx + 4'd1;
    end

    assign o_pop = load && sel_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 4'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= n_idx;
        end else if (advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_crc        <= n_crc;
            r_kind       <= sel_kind;
            r_tx_byte    <= sel_byte;
            r_ack_status <= sel_status;
            r_last       <= sel_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_tx_byte    = r_tx_byte;
    assign o_ack_status = r_ack_status;
    assign o_last       = r_last;

    // a job in progress stays at the queue head until its last byte
    `ASSERT_IMPLY(a_mid_job_head, i_clk, i_rst_n, r_idx != 4'd0, !i_empty)
    `ASSERT_IMPLY(a_idx_range, i_clk, i_rst_n, 1'b1, r_idx <= HDR_LAST_IDX)
    `ASSERT_IMPLY(a_verdict_single, i_clk, i_rst_n, r_valid && r_kind == KIND_VERDICT,
                  r_last && r_tx_byte == 8'h00)

endmodule

@@ verif/rpc_command_framer_unit_test.sv @@
`timescale 1ns / 100ps
// testbench for rpc_command_framer_unit: directed and random op beats in, link bytes
// and ack verdicts out, each checked against an in-bench predictor of the framer
// depends on rcf_pkg and the framer rtl
module rpc_command_framer_unit_test;
    import rcf_pkg::*;

    localparam int          RESET_CYCLES = 6;
    localparam int          RANDOM_BEATS = 270;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          REPORT_LIMIT = 10;
    // slowest legal run is about 0.45 ms: every beat a header, every byte a long stall
    localparam int          WATCHDOG_NS  = 3_000_000;
    localparam logic [31:0] HASH_MUL     = 32'd33;
    // op code the block has no use for
    localparam logic [2:0]  OP_UNUSED    = 3'd7;

    // one result beat as it should show up on the output channel
    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        t_ack_status status;
        logic        last;
    } link_beat_t;

    // crc-16/ccitt-false, one message bit at a time, msb first
    function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ b[k];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // tracks the framer's own state and the link beats still owed
    class link_frame_checker;
        logic [31:0] name_hash;
        logic [15:0] data_crc;
        logic [1:0]  ack_count;
        logic [15:0] ack_crc;
        logic [15:0] ack_magic;
        logic [7:0]  ack_crc_lo;
        link_beat_t  expected_link_beats[$];
        int          mismatches;
        int          checked;

        function new();
            name_hash  = HASH_SEED;
            data_crc   = CRC_SEED;
            mismatches = 0;
            checked    = 0;
            drop_ack();
        endfunction

        function void drop_ack();
            ack_count  = 2'd0;
            ack_crc    = CRC_SEED;
            ack_magic  = 16'h0000;
            ack_crc_lo = 8'h00;
        endfunction

        // accepted input beat: update state, queue the results it owes
        function void note_beat(logic [2:0] op, logic [7:0] b, logic [31:0] len, logic sel);
            logic [7:0]  link_bytes[$];
            logic [15:0] crc;
            logic [15:0] magic;
            link_beat_t  r;
            case (op)
                OP_NAME: begin
                    name_hash = (name_hash * HASH_MUL) ^ {24'd0, b};
                end
                OP_HEADER: begin
                    link_bytes.push_back(CMD_HDR_MAGIC[7:0]);
                    link_bytes.push_back(CMD_HDR_MAGIC[15:8]);
                    for (int k = 0; k < 4; k++) link_bytes.push_back(name_hash[8*k +: 8]);
                    for (int k = 0; k < 4; k++) link_bytes.push_back(len[8*k +: 8]);
                    crc = CRC_SEED;
                    foreach (link_bytes[k]) crc = crc16_update(crc, link_bytes[k]);
                    link_bytes.push_back(crc[7:0]);
                    link_bytes.push_back(crc[15:8]);
                    name_hash = HASH_SEED;
                    drop_ack();
                end
                OP_DATA_START: begin
                    link_bytes.push_back(CMD_DATA_MAGIC[7:0]);
                    link_bytes.push_back(CMD_DATA_MAGIC[15:8]);
                    data_crc = crc16_update(crc16_update(CRC_SEED, CMD_DATA_MAGIC[7:0]),
                                            CMD_DATA_MAGIC[15:8]);
                end
                OP_PAYLOAD: begin
                    data_crc = crc16_update(data_crc, b);
                    link_bytes.push_back(b);
                end
                OP_DATA_END: begin
                    link_bytes.push_back(data_crc[7:0]);
                    link_bytes.push_back(data_crc[15:8]);
                    data_crc = CRC_SEED;
                    drop_ack();
                end
                OP_ACK: begin
                    if (ack_count < 2'd2) begin
                        if (ack_count == 2'd0) ack_magic[7:0] = b;
                        else ack_magic[15:8] = b;
                        ack_crc   = crc16_update(ack_crc, b);
                        ack_count = ack_count + 2'd1;
                    end else if (ack_count == 2'd2) begin
                        ack_crc_lo = b;
                        ack_count  = 2'd3;
                    end else begin
                        // crc is judged before the magic
                        r.kind    = KIND_VERDICT;
                        r.tx_byte = 8'h00;
                        r.last    = 1'b1;
                        if ({b, ack_crc_lo} != ack_crc) r.status = ACK_CRC_MISMATCH;
                        else if (ack_magic != (sel ? CMD_DATA_MAGIC : CMD_HDR_MAGIC))
                            r.status = ACK_WRONG_MAGIC;
                        else r.status = ACK_OK;
                        expected_link_beats.push_back(r);
                        drop_ack();
                    end
                end
                OP_REQUEST: begin
                    magic = sel ? RES_DATA_MAGIC : RES_HDR_MAGIC;
                    crc   = crc16_update(crc16_update(CRC_SEED, magic[7:0]), magic[15:8]);
                    link_bytes.push_back(magic[7:0]);
                    link_bytes.push_back(magic[15:8]);
                    link_bytes.push_back(crc[7:0]);
                    link_bytes.push_back(crc[15:8]);
                    drop_ack();
                end
                default: begin
                end
            endcase
            foreach (link_bytes[k]) begin
                r.kind    = KIND_TX;
                r.tx_byte = link_bytes[k];
                r.status  = ACK_OK;
                r.last    = (k == link_bytes.size() - 1);
                expected_link_beats.push_back(r);
            end
        endfunction

        // accepted output beat against the oldest owed result
        function void check_beat(logic kind, logic [7:0] tx, logic [1:0] status, logic last);
            link_beat_t want;
            if (expected_link_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result beat: kind %0b byte %02h status %0d last %0b",
                             kind, tx, status, last);
                return;
            end
            want = expected_link_beats.pop_front();
            checked++;
            if (kind !== want.kind || tx !== want.tx_byte || status !== want.status ||
                last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"mismatch on result %0d: want kind %0b byte %02h status %0d ",
                              "last %0b, got kind %0b byte %02h status %0d last %0b"},
                             checked, want.kind, want.tx_byte, want.status, want.last,
                             kind, tx, status, last);
            end
        endfunction
    endclass

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_stall;
    logic [2:0]  i_op             = 3'd0;
    logic [7:0]  i_data_byte      = 8'h00;
    logic [31:0] i_payload_length = 32'd0;
    logic        i_select_data    = 1'b0;
    logic        o_valid;
    logic        i_stall          = 1'b0;
    logic        o_kind;
    logic [7:0]  o_tx_byte;
    logic [1:0]  o_ack_status;
    logic        o_last;

    link_frame_checker framer_model = new();

    // beats taken by the block, op 7 not counted
    int beats_taken = 0;
    // when set the sender runs back to back with no idle cycles
    bit sender_steady = 1'b0;

    rpc_command_framer_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_data_byte     (i_data_byte),
        .i_payload_length(i_payload_length),
        .i_select_data   (i_select_data),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_tx_byte       (o_tx_byte),
        .o_ack_status    (o_ack_status),
        .o_last          (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // offer one input beat and hold it until taken, then maybe idle a while;
    // valid is only lowered when a gap follows, so a back-to-back beat never
    // sees valid dropped and raised in the same step
    task automatic send_beat(input logic [2:0] op, input logic [7:0] b,
                             input logic [31:0] len, input logic sel);
        int gap;
        i_valid          <= 1'b1;
        i_op             <= op;
        i_data_byte      <= b;
        i_payload_length <= len;
        i_select_data    <= sel;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        framer_model.note_beat(op, b, len, sel);
        if (op != OP_UNUSED) beats_taken++;
        if (sender_steady) begin
            gap = 0;
        end else begin
            // mostly no gap or a short one, now and then a long one
            gap = $urandom_range(0, 99);
            gap = (gap < 55) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // four ack beats: magic then crc, both low byte first; corrupt spoils the crc
    task automatic send_ack_packet(input logic [15:0] magic, input bit corrupt,
                                   input logic sel);
        logic [15:0] crc;
        crc = crc16_update(crc16_update(CRC_SEED, magic[7:0]), magic[15:8]);
        if (corrupt) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        send_beat(OP_ACK, magic[7:0], $urandom, 1'($urandom));
        send_beat(OP_ACK, magic[15:8], $urandom, 1'($urandom));
        send_beat(OP_ACK, crc[7:0], $urandom, 1'($urandom));
        send_beat(OP_ACK, crc[15:8], $urandom, sel);
    endtask

    // a well-formed command: name, header, data packet with its payload
    task automatic send_command(input int n_name, input int n_payload);
        logic [31:0] len;
        int          mix;
        mix = $urandom_range(0, 9);
        len = (mix == 0) ? 32'd0 : (mix == 1) ? 32'hFFFF_FFFF :
              (mix < 5) ? 32'($urandom_range(0, 1024)) : $urandom;
        repeat (n_name) send_beat(OP_NAME, 8'($urandom), $urandom, 1'($urandom));
        send_beat(OP_HEADER, 8'($urandom), len, 1'($urandom));
        send_beat(OP_DATA_START, 8'($urandom), $urandom, 1'($urandom));
        repeat (n_payload) send_beat(OP_PAYLOAD, 8'($urandom), $urandom, 1'($urandom));
        send_beat(OP_DATA_END, 8'($urandom), $urandom, 1'($urandom));
    endtask

    // hold the sender off until every owed result has left the block;
    // always waits at least one edge so valid is not touched twice in a step
    task automatic wait_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (framer_model.expected_link_beats.size() != 0);
    endtask

    // receiver: free and stalled runs, mostly short, now and then long;
    // long free runs give stretches with no back-pressure at all
    initial begin
        int run;
        wait (i_rst_n === 1'b1);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 8);
            i_stall <= 1'b0;
            repeat (run) @(posedge i_clk);
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
            i_stall <= 1'b1;
            repeat (run) @(posedge i_clk);
        end
    end

    // output beats are taken where valid is high and stall low
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            framer_model.check_beat(o_kind, o_tx_byte, o_ack_status, o_last);
    end

    initial begin
        int          random_start;
        int          pick;
        int          mix;
        bit          paused_once;
        logic        sel;
        logic [15:0] magic;
        paused_once = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: data end with no data start sends the crc seed
        send_beat(OP_DATA_END, 8'h5A, 32'd0, 1'b0);
        // payload with no data start still folds into the data crc
        send_beat(OP_PAYLOAD, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        // name byte extremes, then two headers: the second sees the hash seed again
        send_beat(OP_NAME, 8'h00, 32'hFFFF_FFFF, 1'b1);
        send_beat(OP_NAME, 8'hFF, 32'd0, 1'b0);
        send_beat(OP_HEADER, 8'h00, 32'hFFFF_FFFF, 1'b1);
        send_beat(OP_HEADER, 8'hFF, 32'd0, 1'b0);
        // full data packet with payload extremes
        send_beat(OP_DATA_START, 8'h00, 32'd0, 1'b0);
        send_beat(OP_PAYLOAD, 8'h00, 32'd0, 1'b0);
        send_beat(OP_PAYLOAD, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_beat(OP_DATA_END, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        // good header ack
        send_ack_packet(CMD_HDR_MAGIC, 1'b0, 1'b0);
        // bad crc and wrong magic together: crc wins
        send_ack_packet(CMD_HDR_MAGIC, 1'b1, 1'b1);
        // good crc but the magic is not the one asked for
        send_ack_packet(CMD_HDR_MAGIC, 1'b0, 1'b1);
        // half an ack, then a request throws it away
        send_beat(OP_ACK, CMD_DATA_MAGIC[7:0], 32'd0, 1'b1);
        send_beat(OP_ACK, CMD_DATA_MAGIC[15:8], 32'd0, 1'b1);
        send_beat(OP_REQUEST, 8'h00, 32'd0, 1'b1);
        send_ack_packet(CMD_DATA_MAGIC, 1'b0, 1'b1);
        send_beat(OP_REQUEST, 8'hFF, 32'hFFFF_FFFF, 1'b0);
        // unused op must leave no trace
        send_beat(OP_UNUSED, 8'hA5, 32'h1234_5678, 1'b1);

        // random: mostly well-formed commands and ack packets, some noise
        random_start = beats_taken;
        while (beats_taken < random_start + RANDOM_BEATS) begin
            if (!paused_once && beats_taken >= random_start + RANDOM_BEATS / 2) begin
                wait_until_drained();
                paused_once = 1'b1;
            end
            if ($urandom_range(0, 11) == 0) sender_steady = !sender_steady;
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_command($urandom_range(0, 6), $urandom_range(0, 8));
            end else if (pick < 60) begin
                sel   = 1'($urandom);
                mix   = $urandom_range(0, 9);
                magic = (mix < 5) ? (sel ? CMD_DATA_MAGIC : CMD_HDR_MAGIC) :
                        (mix < 7) ? (sel ? CMD_HDR_MAGIC : CMD_DATA_MAGIC) : 16'($urandom);
                send_ack_packet(magic, $urandom_range(0, 3) == 0, sel);
            end else if (pick < 72) begin
                send_beat(OP_REQUEST, 8'($urandom), $urandom, 1'($urandom));
            end else if (pick < 84) begin
                // broken ack: a few bytes, then whatever comes next
                repeat ($urandom_range(1, 3))
                    send_beat(OP_ACK, 8'($urandom), $urandom, 1'($urandom));
            end else begin
                send_beat(3'($urandom_range(0, 7)), 8'($urandom), $urandom, 1'($urandom));
            end
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (framer_model.expected_link_beats.size() != 0)
            $display("%0d expected results never arrived",
                     framer_model.expected_link_beats.size());
        if (framer_model.mismatches == 0 && framer_model.expected_link_beats.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // hang guard
    initial begin
        #(WATCHDOG_NS);
        $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/rcf_pkg.sv
hdl/rcf_front.sv
hdl/rcf_queue.sv
hdl/rcf_back.sv
hdl/rpc_command_framer_unit.sv
verif/rpc_command_framer_unit_test.sv
